### sv/two_key_sorted_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-key sorted priority queue unit
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define TKPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that, once seen, must be followed by another on the next edge.
`define TKPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TKPQ_ASSERT(lbl, prop, msg)
`define TKPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### sv/tkpq_pkg.sv
// ----------------------------------------------------------------------------
// tkpq_pkg
// Shared codes and types of the two-key sorted priority queue unit.
// ----------------------------------------------------------------------------
package tkpq_pkg;

  // Fixed field widths.
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 2;

  // Operation carried by a request.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  // Status returned with every result.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

### sv/tkpq_cell.sv
// ----------------------------------------------------------------------------
// tkpq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming key and takes data from its left or right neighbor or the new entry.
// ----------------------------------------------------------------------------
module tkpq_cell #(
  parameter int PRIORITY_BITS = 4,
  parameter int TIME_BITS     = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tkpq_pkg::cell_ctrl_t       ctrl,
  input  logic [tkpq_pkg::TAG_W-1:0] new_tag,
  input  logic [PRIORITY_BITS-1:0]   new_pri,
  input  logic [TIME_BITS-1:0]       new_stime,
  input  logic                       left_valid,
  input  logic                       left_behind,
  input  logic [tkpq_pkg::TAG_W-1:0] left_tag,
  input  logic [PRIORITY_BITS-1:0]   left_pri,
  input  logic [TIME_BITS-1:0]       left_stime,
  input  logic                       right_valid,
  input  logic [tkpq_pkg::TAG_W-1:0] right_tag,
  input  logic [PRIORITY_BITS-1:0]   right_pri,
  input  logic [TIME_BITS-1:0]       right_stime,
  output logic                       valid,
  output logic                       behind,
  output logic [tkpq_pkg::TAG_W-1:0] tag,
  output logic [PRIORITY_BITS-1:0]   pri,
  output logic [TIME_BITS-1:0]       stime
);
  import tkpq_pkg::*;

  logic                     valid_r, valid_nxt;
  logic [TAG_W-1:0]         tag_r, tag_nxt;
  logic [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [TIME_BITS-1:0]     stime_r, stime_nxt;
  logic                     outranks;

  // The new key strictly beats this slot: higher priority, or equal
  // priority and an earlier timestamp.
  assign outranks = (new_pri > pri_r) || ((new_pri == pri_r) && (new_stime < stime_r));

  // The new entry lands at or ahead of this slot.
  assign behind = !valid_r || outranks;

  // Insert shifts the tail right; pop shifts everything left.
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    pri_nxt   = pri_r;
    stime_nxt = stime_r;
    if (ctrl.ins) begin
      valid_nxt = left_valid;
      if (behind) begin
        if (left_behind) begin
          tag_nxt   = left_tag;
          pri_nxt   = left_pri;
          stime_nxt = left_stime;
        end else begin
          tag_nxt   = new_tag;
          pri_nxt   = new_pri;
          stime_nxt = new_stime;
        end
      end
    end else if (ctrl.pop) begin
      valid_nxt = right_valid;
      tag_nxt   = right_tag;
      pri_nxt   = right_pri;
      stime_nxt = right_stime;
    end
  end

  // Only the valid bit is reset; the payload is meaningful while valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    pri_r   <= pri_nxt;
    stime_r <= stime_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign pri   = pri_r;
  assign stime = stime_r;

endmodule

### sv/tkpq_outbuf.sv
// ----------------------------------------------------------------------------
// tkpq_outbuf
// Two-entry result buffer: an output register backed by a skid register, so
// a new request is taken while one finished result waits downstream.
// ----------------------------------------------------------------------------
module tkpq_outbuf #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_stall,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data,
  input  logic             out_stall
);
  import tkpq_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [WIDTH-1:0] skid_data_r, skid_data_nxt;
  logic             push;
  logic             take;

  assign push_stall = skid_valid_r;
  assign push       = push_valid && !skid_valid_r;
  assign take       = out_valid_r && !out_stall;

  // Refill the output from the skid stage first, else from a new push.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/two_key_sorted_priority_queue_unit.sv
// Sorted priority queue of up to CAPACITY entries, ranked by higher priority
// first and then by earlier timestamp, with ties kept in arrival order. Every
// slot is a cell of a chain that compares the new key with its own entry in
// parallel and shifts by one place toward or away from the head in the cycle
// that a request, insert or pop, is taken. Each request gives one result,
// registered in a two-entry output buffer, so requests flow at one per cycle
// and in_stall rises only when that buffer holds two results not yet taken.
// ----------------------------------------------------------------------------
// two_key_sorted_priority_queue_unit
// Top level: request decode, chain of slot cells, occupancy count and the
// result buffer.
// ----------------------------------------------------------------------------
`include "two_key_sorted_priority_queue_unit_assert.svh"

module two_key_sorted_priority_queue_unit #(
  parameter int CAPACITY      = 16,
  parameter int PRIORITY_BITS = 4,
  parameter int TIME_BITS     = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_opcode,
  input  logic [tkpq_pkg::TAG_W-1:0]              in_entry_tag,
  input  logic [PRIORITY_BITS-1:0]                in_entry_priority,
  input  logic [TIME_BITS-1:0]                    in_entry_time,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [tkpq_pkg::STATUS_W-1:0]           out_status,
  output logic [tkpq_pkg::TAG_W-1:0]              out_head_tag,
  output logic [PRIORITY_BITS-1:0]                out_head_priority,
  output logic [TIME_BITS-1:0]                    out_head_time,
  output logic [$clog2(CAPACITY+1)-1:0]           out_occupancy
);
  import tkpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RES_W = STATUS_W + TAG_W + PRIORITY_BITS + TIME_BITS + CNT_W;

  logic                     accept;
  logic                     is_insert;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  logic [CNT_W-1:0]         count_r, count_nxt;
  status_t                  status;
  logic [TAG_W-1:0]         res_tag;
  logic [PRIORITY_BITS-1:0] res_pri;
  logic [TIME_BITS-1:0]     res_time;
  logic [RES_W-1:0]         res_data;
  logic [RES_W-1:0]         buf_data;

  logic [CAPACITY-1:0]      valid_w;
  logic [CAPACITY-1:0]      behind_w;
  logic [TAG_W-1:0]         tag_w   [CAPACITY];
  logic [PRIORITY_BITS-1:0] pri_w   [CAPACITY];
  logic [TIME_BITS-1:0]     stime_w [CAPACITY];

  // Request decode; a full insert or an empty pop leaves the chain alone.
  assign accept    = in_valid && !in_stall;
  assign is_insert = (opcode_t'(in_opcode) == OP_INSERT);
  assign full      = valid_w[CAPACITY-1];
  assign empty     = !valid_w[0];
  assign ctrl.ins  = accept && is_insert && !full;
  assign ctrl.pop  = accept && !is_insert && !empty;

  // Chain of slot cells, slot 0 at the head.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                     l_valid, l_behind, r_valid;
    logic [TAG_W-1:0]         l_tag, r_tag;
    logic [PRIORITY_BITS-1:0] l_pri, r_pri;
    logic [TIME_BITS-1:0]     l_stime, r_stime;

    if (k == 0) begin : g_head
      assign l_valid  = 1'b1;
      assign l_behind = 1'b0;
      assign l_tag    = '0;
      assign l_pri    = '0;
      assign l_stime  = '0;
    end else begin : g_left
      assign l_valid  = valid_w[k-1];
      assign l_behind = behind_w[k-1];
      assign l_tag    = tag_w[k-1];
      assign l_pri    = pri_w[k-1];
      assign l_stime  = stime_w[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_tag   = '0;
      assign r_pri   = '0;
      assign r_stime = '0;
    end else begin : g_right
      assign r_valid = valid_w[k+1];
      assign r_tag   = tag_w[k+1];
      assign r_pri   = pri_w[k+1];
      assign r_stime = stime_w[k+1];
    end

    tkpq_cell #(
      .PRIORITY_BITS (PRIORITY_BITS),
      .TIME_BITS     (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_tag     (in_entry_tag),
      .new_pri     (in_entry_priority),
      .new_stime   (in_entry_time),
      .left_valid  (l_valid),
      .left_behind (l_behind),
      .left_tag    (l_tag),
      .left_pri    (l_pri),
      .left_stime  (l_stime),
      .right_valid (r_valid),
      .right_tag   (r_tag),
      .right_pri   (r_pri),
      .right_stime (r_stime),
      .valid       (valid_w[k]),
      .behind      (behind_w[k]),
      .tag         (tag_w[k]),
      .pri         (pri_w[k]),
      .stime       (stime_w[k])
    );
  end

  // Occupancy count.
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result fields; the head entry is reported only on a successful pop.
  always_comb begin
    res_tag  = '0;
    res_pri  = '0;
    res_time = '0;
    if (is_insert) begin
      status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      status = ST_EMPTY;
    end else begin
      status   = ST_POPPED;
      res_tag  = tag_w[0];
      res_pri  = pri_w[0];
      res_time = stime_w[0];
    end
  end

  assign res_data = {status, res_tag, res_pri, res_time, count_nxt};

  // Result buffer.
  tkpq_outbuf #(
    .WIDTH (RES_W)
  ) u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_data  (res_data),
    .push_stall (in_stall),
    .out_valid  (out_valid),
    .out_data   (buf_data),
    .out_stall  (out_stall)
  );

  assign {out_status, out_head_tag, out_head_priority, out_head_time, out_occupancy} = buf_data;

  // Checks: the count tracks the valid cells, the two front slots are in
  // rank order, and a successful pop lowers the count by one.
  logic second_beats_head;
  assign second_beats_head = (pri_w[1] > pri_w[0]) ||
                             ((pri_w[1] == pri_w[0]) && (stime_w[1] < stime_w[0]));

  `TKPQ_ASSERT(a_count_matches_cells, $countones(valid_w) == count_r, "count differs from cells")
  `TKPQ_ASSERT(a_head_sorted, valid_w[1] |-> !second_beats_head, "head pair out of order")
  `TKPQ_ASSERT_NEXT(a_pop_count, ctrl.pop, count_r == $past(count_r) - 1'b1, "pop count slip")

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key sorted priority queue unit testbench
// Drives insert and pop requests through the valid/stall request channel,
// keeps a shadow copy of the sorted queue to work out each result, and checks
// every result field by field. It covers directed edge cases, fill and drain
// bursts with random keys, random mixed traffic, and a stretch without idling.
// ----------------------------------------------------------------------------
module testbench;
  import tkpq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int PRI_W    = 4;
  localparam int TIME_W   = 32;
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  // One result as the block should report it.
  typedef struct {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [PRI_W-1:0]   prio;
    logic [TIME_W-1:0]  stamp;
    logic [OCC_W-1:0]   occupancy;
  } queue_outcome_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_opcode = 1'b0;
  logic [TAG_W-1:0]    in_entry_tag = '0;
  logic [PRI_W-1:0]    in_entry_priority = '0;
  logic [TIME_W-1:0]   in_entry_time = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [TAG_W-1:0]    out_head_tag;
  logic [PRI_W-1:0]    out_head_priority;
  logic [TIME_W-1:0]   out_head_time;
  logic [OCC_W-1:0]    out_occupancy;

  // Shadow copy of the sorted slots; slot 0 is the head.
  logic [TAG_W-1:0]    shadow_tag [CAPACITY];
  logic [PRI_W-1:0]    shadow_prio [CAPACITY];
  logic [TIME_W-1:0]   shadow_stamp [CAPACITY];
  int                  shadow_count = 0;

  queue_outcome_t      pending_outcomes [$];
  int                  failures = 0;
  bit                  idling_on = 1'b1;

  two_key_sorted_priority_queue_unit #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRI_W),
    .TIME_BITS     (TIME_W)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_entry_tag      (in_entry_tag),
    .in_entry_priority (in_entry_priority),
    .in_entry_time     (in_entry_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_head_tag      (out_head_tag),
    .out_head_priority (out_head_priority),
    .out_head_time     (out_head_time),
    .out_occupancy     (out_occupancy)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random unless idling is switched off.
  always @(posedge clk) begin
    out_stall <= idling_on ? ($urandom_range(99) < 34) : 1'b0;
  end

  // Applies one accepted request to the shadow queue and records its result.
  task automatic shadow_queue_step(input opcode_t op, input logic [TAG_W-1:0] tag,
                                   input logic [PRI_W-1:0] prio,
                                   input logic [TIME_W-1:0] stamp);
    queue_outcome_t res;
    int pos;
    res.tag = '0;
    res.prio = '0;
    res.stamp = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // Walk toward the head past every entry that the new key strictly outranks.
        pos = shadow_count;
        while (pos > 0 && (prio > shadow_prio[pos-1] ||
               (prio == shadow_prio[pos-1] && stamp < shadow_stamp[pos-1]))) begin
          shadow_tag[pos] = shadow_tag[pos-1];
          shadow_prio[pos] = shadow_prio[pos-1];
          shadow_stamp[pos] = shadow_stamp[pos-1];
          pos--;
        end
        shadow_tag[pos] = tag;
        shadow_prio[pos] = prio;
        shadow_stamp[pos] = stamp;
        shadow_count++;
        res.status = ST_INSERTED;
      end
    end else begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.tag = shadow_tag[0];
        res.prio = shadow_prio[0];
        res.stamp = shadow_stamp[0];
        for (pos = 0; pos + 1 < shadow_count; pos++) begin
          shadow_tag[pos] = shadow_tag[pos+1];
          shadow_prio[pos] = shadow_prio[pos+1];
          shadow_stamp[pos] = shadow_stamp[pos+1];
        end
        shadow_count--;
        res.status = ST_POPPED;
      end
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    pending_outcomes.push_back(res);
  endtask

  // Sends one request, with random idle cycles ahead of it, and waits until
  // the block takes it.
  task automatic send_request(input opcode_t op, input logic [TAG_W-1:0] tag,
                              input logic [PRI_W-1:0] prio,
                              input logic [TIME_W-1:0] stamp);
    while (idling_on && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_tag <= tag;
    in_entry_priority <= prio;
    in_entry_time <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow_queue_step(op, tag, prio, stamp);
  endtask

  // Priorities lean toward the extremes and a narrow middle band to make ties.
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return PRI_W'($urandom_range(6, 9));
      default: return PRI_W'($urandom_range(15));
    endcase
  endfunction

  // Timestamps lean toward the extremes and a few small values to make ties.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      2:       return TIME_W'($urandom_range(3));
      default: return TIME_W'($urandom());
    endcase
  endfunction

  task automatic send_random_insert();
    send_request(OP_INSERT, TAG_W'($urandom_range(255)), pick_priority(), pick_time());
  endtask

  task automatic send_random_pop();
    // Payload fields are ignored on a pop, so they carry noise.
    send_request(OP_POP, TAG_W'($urandom_range(255)), PRI_W'($urandom_range(15)),
                 TIME_W'($urandom()));
  endtask

  task automatic test_pop_on_empty();
    send_request(OP_POP, '1, '1, '1);
  endtask

  // Fills the queue with extreme keys and exact ties of priority and timestamp.
  task automatic test_fill_with_extremes();
    send_request(OP_INSERT, 8'h00, 4'd0,  32'h0000_0000);
    send_request(OP_INSERT, 8'hFF, 4'd15, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'h01, 4'd15, 32'h0000_0000);
    send_request(OP_INSERT, 8'h02, 4'd15, 32'h0000_0000);
    send_request(OP_INSERT, 8'h03, 4'd15, 32'h0000_0000);
    send_request(OP_INSERT, 8'h04, 4'd0,  32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'hAA, 4'd5,  32'd100);
    send_request(OP_INSERT, 8'h55, 4'd5,  32'd99);
    send_request(OP_INSERT, 8'h10, 4'd5,  32'd100);
    send_request(OP_INSERT, 8'h80, 4'd10, 32'h8000_0000);
    send_request(OP_INSERT, 8'h7F, 4'd10, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 8'h20, 4'd0,  32'h0000_0000);
    send_request(OP_INSERT, 8'h21, 4'd1,  32'h5555_5555);
    send_request(OP_INSERT, 8'h22, 4'd14, 32'hAAAA_AAAA);
    send_request(OP_INSERT, 8'h23, 4'd8,  32'd1);
    send_request(OP_INSERT, 8'h24, 4'd7,  32'hFFFF_FFFE);
  endtask

  // The queue is full here, so a top-ranked insert is still dropped.
  task automatic test_insert_when_full();
    send_request(OP_INSERT, 8'hFE, 4'd15, 32'h0000_0000);
  endtask

  task automatic test_drain_order();
    repeat (5) send_random_pop();
  endtask

  // Runs of inserts then runs of pops, long enough to reach both full and empty.
  task automatic test_fill_drain_bursts(input int n_items);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      run = $urandom_range(1, CAPACITY + 4);
      repeat (run) send_random_insert();
      sent += run;
      run = $urandom_range(1, CAPACITY + 4);
      repeat (run) send_random_pop();
      sent += run;
    end
  endtask

  task automatic test_random_mixed(input int n_items);
    repeat (n_items) begin
      if ($urandom_range(1)) send_random_pop();
      else send_random_insert();
    end
  endtask

  // Back-to-back requests with the result side never stalling.
  task automatic test_without_idling(input int n_items);
    idling_on = 1'b0;
    test_fill_drain_bursts(n_items);
    idling_on = 1'b1;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Compares each taken result with the oldest outstanding one.
  always @(posedge clk) begin
    queue_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with none outstanding: expected none, actual status %0d",
                 $time, out_status);
        failures++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("status", want.status, out_status);
        check_field("head_tag", want.tag, out_head_tag);
        check_field("head_priority", want.prio, out_head_priority);
        check_field("head_time", want.stamp, out_head_time);
        check_field("occupancy", want.occupancy, out_occupancy);
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_pop_on_empty();
    test_fill_with_extremes();
    test_insert_when_full();
    test_drain_order();
    test_fill_drain_bursts(650);
    test_random_mixed(250);
    test_without_idling(250);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/tkpq_pkg.sv
sv/tkpq_cell.sv
sv/tkpq_outbuf.sv
sv/two_key_sorted_priority_queue_unit.sv
dv/testbench.sv
